/* design/rpbt_pkg.sv */
package rpbt_pkg;

  localparam int MAX_PACKETS = 2048;
  localparam int INDEX_REACH = 2048;
  localparam int MAP_BITS    = (MAX_PACKETS < INDEX_REACH) ? MAX_PACKETS : INDEX_REACH;
  localparam int WORD_W      = 32;
  localparam int WORD_LSB    = $clog2(WORD_W);
  localparam int DEPTH       = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [6:0] REPORT_CAP = 7'd64;

  localparam logic CFG_TOTAL_PACKETS = 1'b0;
  localparam logic CFG_MAX_REPORT    = 1'b1;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_RECV  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_STARTED = 3'd0,
    ST_NEW     = 3'd1,
    ST_DUP     = 3'd2,
    ST_RANGE   = 3'd3,
    ST_LOST    = 3'd4,
    ST_NONE    = 3'd5
  } status_t;

  typedef struct packed {
    req_t        req_type;
    logic [10:0] packet_index;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic [10:0] lost_index;
    logic        is_last;
  } out_t;

endpackage

/* design/received_packet_bitmap_tracker.sv */
// Start, out-of-range receive: the result is registered and out in the cycle after accept.
// In-range receive: map word registered, checked in S_CHK, result registered; busy until done.
// Lost query: S_SCAN_WORD reads each 32-bit word, S_SCAN_EMIT reports its indices, S_FINISH ends.
// Results come out as one-cycle out_valid strobes; the receiver cannot stall.
// Reset (synchronous, rst_n low): map reads all-missing via per-word valid bits,
// total_packets = 0, max_report = 64, block idle.
module received_packet_bitmap_tracker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  rpbt_pkg::in_t        in_data,
  output logic                 out_valid,
  output rpbt_pkg::out_t       out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [11:0]          cfg_wdata
);
  import rpbt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_CHK       = 5'b00010,
    S_SCAN_WORD = 5'b00100,
    S_SCAN_EMIT = 5'b01000,
    S_FINISH    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [11:0] total_packets_r;
  logic [6:0]  max_report_r;

  // map storage: one bit per packet, 1 = missing; invalid words read as all missing
  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [WORD_W-1:0] rdata_r;
  logic              rvalid_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wdata;
  logic              clear_all;

  logic [10:0]       req_idx_r, req_idx_nxt;
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [WORD_W-1:0] pend_r, pend_nxt;
  logic [6:0]        count_r, count_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  logic [10:0]       hold_idx_r, hold_idx_nxt;

  logic              emit;
  out_t              emit_data;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [11:0]       span;
  logic [6:0]        limit;
  logic [ADDR_W-1:0] last_word;
  logic [WORD_W-1:0] word;
  logic [11:0]       base;
  logic [11:0]       hi;
  logic [WORD_W-1:0] mask;
  logic [WORD_LSB-1:0] low_bit;
  logic [10:0]       found_idx;

  function automatic logic [WORD_LSB-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_LSB-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) pos = WORD_LSB'(i);
    end
    return pos;
  endfunction

  assign span  = (total_packets_r > 12'(MAP_BITS)) ? 12'(MAP_BITS) : total_packets_r;
  assign limit = (max_report_r == 7'd0) ? 7'd1 :
                 (max_report_r > REPORT_CAP) ? REPORT_CAP : max_report_r;
  assign last_word = ADDR_W'((span - 12'd1) >> WORD_LSB);

  assign word    = rvalid_r ? rdata_r : '1;
  assign base    = 12'({scan_addr_r, {WORD_LSB{1'b0}}});
  assign hi      = span - base;
  assign mask    = (hi >= 12'(WORD_W)) ? '1 : ((WORD_W'(1) << hi[WORD_LSB-1:0]) - WORD_W'(1));
  assign low_bit = lowest_set(pend_r);
  assign found_idx = 11'({scan_addr_r, low_bit});

  always_comb begin
    state_nxt      = state_r;
    req_idx_nxt    = req_idx_r;
    scan_addr_nxt  = scan_addr_r;
    pend_nxt       = pend_r;
    count_nxt      = count_r;
    hold_valid_nxt = hold_valid_r;
    hold_idx_nxt   = hold_idx_r;
    rd_addr        = ADDR_W'(in_data.packet_index >> WORD_LSB);
    we             = 1'b0;
    wr_addr        = ADDR_W'(req_idx_r >> WORD_LSB);
    wdata          = word & ~(WORD_W'(1) << req_idx_r[WORD_LSB-1:0]);
    clear_all      = 1'b0;
    emit           = 1'b0;
    emit_data      = '{status: ST_STARTED, lost_index: 11'd0, is_last: 1'b1};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_data.req_type)
            REQ_START: begin
              clear_all = 1'b1;
              emit      = 1'b1;
            end
            REQ_RECV: begin
              if (12'(in_data.packet_index) >= span) begin
                emit             = 1'b1;
                emit_data.status = ST_RANGE;
              end else begin
                req_idx_nxt = in_data.packet_index;
                state_nxt   = S_CHK;
              end
            end
            REQ_QUERY: begin
              count_nxt      = '0;
              hold_valid_nxt = 1'b0;
              scan_addr_nxt  = '0;
              rd_addr        = '0;
              state_nxt      = (span == 12'd0) ? S_FINISH : S_SCAN_WORD;
            end
            REQ_NOP: ;
            default: ;
          endcase
        end
      end
      S_CHK: begin
        emit = 1'b1;
        if (word[req_idx_r[WORD_LSB-1:0]]) begin
          we               = 1'b1;
          emit_data.status = ST_NEW;
        end else begin
          emit_data.status = ST_DUP;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN_WORD: begin
        pend_nxt  = word & mask;
        state_nxt = S_SCAN_EMIT;
      end
      S_SCAN_EMIT: begin
        if (pend_r == '0) begin
          if (scan_addr_r == last_word) begin
            state_nxt = S_FINISH;
          end else begin
            scan_addr_nxt = scan_addr_r + ADDR_W'(1);
            rd_addr       = scan_addr_r + ADDR_W'(1);
            state_nxt     = S_SCAN_WORD;
          end
        end else begin
          // the previous index goes out only once a later one is known to exist
          if (hold_valid_r) begin
            emit      = 1'b1;
            emit_data = '{status: ST_LOST, lost_index: hold_idx_r, is_last: 1'b0};
          end
          pend_nxt       = pend_r & ~(WORD_W'(1) << low_bit);
          hold_valid_nxt = 1'b1;
          hold_idx_nxt   = found_idx;
          count_nxt      = count_r + 7'd1;
          if (count_r + 7'd1 == limit) state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        emit = 1'b1;
        if (hold_valid_r) begin
          emit_data = '{status: ST_LOST, lost_index: hold_idx_r, is_last: 1'b1};
        end else begin
          emit_data.status = ST_NONE;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r  <= mem[rd_addr];
    rvalid_r <= valid_r[rd_addr];
    if (we) mem[wr_addr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      valid_r         <= '0;
      out_valid_r     <= 1'b0;
      total_packets_r <= 12'd0;
      max_report_r    <= 7'd64;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (clear_all) valid_r <= '0;
      else if (we) valid_r[wr_addr] <= 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOTAL_PACKETS: total_packets_r <= cfg_wdata;
          CFG_MAX_REPORT:    max_report_r    <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_idx_r    <= req_idx_nxt;
    scan_addr_r  <= scan_addr_nxt;
    pend_r       <= pend_nxt;
    count_r      <= count_nxt;
    hold_valid_r <= hold_valid_nxt;
    hold_idx_r   <= hold_idx_nxt;
    if (emit) out_data_r <= emit_data;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* design/rpbt_checker.sv */
module rpbt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input rpbt_pkg::in_t  in_data,
  input logic           out_valid,
  input rpbt_pkg::out_t out_data
);
  import rpbt_pkg::*;

  // a start item answers on the very next cycle
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.req_type == REQ_START |=>
      out_valid && out_data.status == ST_STARTED && out_data.is_last)
    else $error("start item not answered next cycle");

  // a receive item either answers at once or holds busy for its map check
  a_recv_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.req_type == REQ_RECV |=> out_valid || busy)
    else $error("receive item dropped");

  // only lost entries may be non-final, and only they carry an index
  a_single_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_LOST |-> out_data.is_last && out_data.lost_index == 11'd0)
    else $error("single result not final or index not zero");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

endmodule

bind received_packet_bitmap_tracker rpbt_checker u_rpbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

/* verif/tb_received_packet_bitmap_tracker.sv */
module tb_received_packet_bitmap_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  import rpbt_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 480;

  // Tracks the missing-packet map and the reports it should produce.
  class missing_map_board;
    bit [MAX_PACKETS-1:0] missing;
    bit [11:0]            total_packets;
    bit [6:0]             max_report;
    out_t                 pending_reports[$];
    int                   errors;

    function new();
      missing       = '1;
      total_packets = '0;
      max_report    = REPORT_CAP;
      errors        = 0;
    endfunction

    function void write_reg(logic idx, logic [11:0] value);
      if (idx == CFG_TOTAL_PACKETS) begin
        total_packets = value;
      end else begin
        max_report = value[6:0];
      end
    endfunction

    function int span();
      int n = total_packets;
      if (n > MAX_PACKETS) n = MAX_PACKETS;
      if (n > INDEX_REACH) n = INDEX_REACH;
      return n;
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    function void push(status_t st, int idx, bit last);
      out_t r;
      r.status     = st;
      r.lost_index = 11'(idx);
      r.is_last    = last;
      pending_reports.push_back(r);
    endfunction

    function void take_request(in_t it);
      int   n;
      int   limit;
      int   count;
      out_t tail;
      n = span();
      case (it.req_type)
        REQ_START: begin
          missing = '1;
          push(ST_STARTED, 0, 1'b1);
        end
        REQ_RECV: begin
          if (it.packet_index >= n) begin
            push(ST_RANGE, 0, 1'b1);
          end else if (missing[it.packet_index]) begin
            missing[it.packet_index] = 1'b0;
            push(ST_NEW, 0, 1'b1);
          end else begin
            push(ST_DUP, 0, 1'b1);
          end
        end
        REQ_QUERY: begin
          // zero limit reads as one, anything past the cap saturates
          limit = (max_report == 0) ? 1 : (max_report > REPORT_CAP) ? REPORT_CAP : max_report;
          count = 0;
          for (int i = 0; i < n && count < limit; i++) begin
            if (missing[i]) begin
              push(ST_LOST, i, 1'b0);
              count++;
            end
          end
          if (count == 0) begin
            push(ST_NONE, 0, 1'b1);
          end else begin
            tail = pending_reports.pop_back();
            tail.is_last = 1'b1;
            pending_reports.push_back(tail);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_report(out_t got);
      out_t want;
      if (pending_reports.size() == 0) begin
        $error("unexpected result: status=%0d lost_index=%0d is_last=%0b",
               got.status, got.lost_index, got.is_last);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.lost_index !== want.lost_index) begin
        $error("lost_index: expected %0d, got %0d", want.lost_index, got.lost_index);
        errors++;
      end
      if (got.is_last !== want.is_last) begin
        $error("is_last: expected %0b, got %0b", want.is_last, got.is_last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [11:0] cfg_wdata;

  missing_map_board board;
  int sender_idle_pct = 0;
  int sent_items      = 0;
  int quiet_cycles    = 0;
  int sweep_idx       = 0;

  received_packet_bitmap_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) board.take_request(in_data);
      if (out_valid) board.check_report(out_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Leaves start high after the accept so back-to-back items need no toggle.
  task automatic send_item(req_t req, logic [10:0] idx);
    in_t item;
    item.req_type     = req;
    item.packet_index = idx;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    if (req != REQ_NOP) sent_items++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    // a nop or a closing scan may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic program_regs(logic [11:0] total, logic [6:0] report);
    logic [11:0] report_word;
    report_word = {5'($urandom), report};
    cfg_we      <= 1'b1;
    cfg_index   <= CFG_TOTAL_PACKETS;
    cfg_wdata   <= total;
    @(posedge clk);
    board.write_reg(CFG_TOTAL_PACKETS, total);
    cfg_index   <= CFG_MAX_REPORT;
    cfg_wdata   <= report_word;
    @(posedge clk);
    board.write_reg(CFG_MAX_REPORT, report_word);
    cfg_we      <= 1'b0;
  endtask

  task automatic run_transfer();
    int          n;
    int          k;
    int          r;
    logic [11:0] total;
    logic [6:0]  report;
    r = $urandom_range(99);
    if (r < 8)       total = '0;
    else if (r < 14) total = 12'(MAX_PACKETS);
    else if (r < 18) total = 12'($urandom_range(2049, 4095));
    else if (r < 22) total = 12'($urandom_range(25, 2047));
    else             total = 12'($urandom_range(1, 24));
    r = $urandom_range(99);
    if (r < 10)      report = '0;
    else if (r < 20) report = 7'($urandom_range(65, 127));
    else if (r < 30) report = REPORT_CAP;
    else if (r < 40) report = 7'd1;
    else             report = 7'($urandom_range(2, 16));
    settle();
    program_regs(total, report);
    if ($urandom_range(9) != 0) send_item(REQ_START, 11'($urandom));
    n = board.span();
    k = (n <= 24) ? 3 * n + 4 : $urandom_range(10, 30);
    sweep_idx = 0;
    repeat (k) begin
      r = $urandom_range(99);
      if (r < 70 && n > 0) begin
        // mostly sweep in order so small transfers fill up completely
        if ($urandom_range(99) < 60) begin
          send_item(REQ_RECV, 11'(sweep_idx % n));
          sweep_idx++;
        end else begin
          send_item(REQ_RECV, 11'($urandom_range(0, n - 1)));
        end
      end else if (r < 80) begin
        send_item(REQ_RECV, 11'($urandom));
      end else if (r < 94) begin
        send_item(REQ_QUERY, 11'($urandom));
      end else if (r < 95) begin
        send_item(REQ_START, 11'($urandom));
      end else begin
        send_item(REQ_NOP, 11'($urandom));
      end
    end
    send_item(REQ_QUERY, 11'($urandom));
  endtask

  initial begin
    board = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty transfer after reset, ignored request type
    send_item(REQ_QUERY, 11'd0);
    send_item(REQ_RECV, 11'd0);
    send_item(REQ_NOP, 11'h7ff);
    settle();
    program_regs(12'd5, 7'd0);
    send_item(REQ_QUERY, 11'd0);
    send_item(REQ_RECV, 11'd2);
    send_item(REQ_RECV, 11'd2);
    send_item(REQ_RECV, 11'd5);
    send_item(REQ_RECV, 11'h7ff);
    settle();
    program_regs(12'd5, 7'd127);
    send_item(REQ_QUERY, 11'd0);
    send_item(REQ_RECV, 11'd0);
    send_item(REQ_RECV, 11'd1);
    send_item(REQ_RECV, 11'd3);
    send_item(REQ_RECV, 11'd4);
    send_item(REQ_QUERY, 11'h7ff);
    send_item(REQ_START, 11'h7ff);
    send_item(REQ_QUERY, 11'd0);
    // total above the index reach clamps to the full map
    settle();
    program_regs(12'hfff, REPORT_CAP);
    send_item(REQ_START, 11'd0);
    send_item(REQ_RECV, 11'h7ff);
    send_item(REQ_RECV, 11'h400);
    send_item(REQ_QUERY, 11'd0);
    settle();
    program_regs(12'(MAX_PACKETS), 7'd1);
    send_item(REQ_QUERY, 11'd0);

    sent_items = 0;
    sender_idle_pct = 27;
    while (sent_items < RANDOM_ITEMS / 3) run_transfer();
    sender_idle_pct = 68;
    while (sent_items < 2 * RANDOM_ITEMS / 3) run_transfer();
    sender_idle_pct = 0;
    while (sent_items < RANDOM_ITEMS) run_transfer();
    settle();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* received_packet_bitmap_tracker.f */
design/rpbt_pkg.sv
design/received_packet_bitmap_tracker.sv
design/rpbt_checker.sv
verif/tb_received_packet_bitmap_tracker.sv
